### sv/rar_pkg.sv
// Package for the rational arithmetic unit: field widths, operation and form codes,
// state encodings and the command and status structs between controller and datapath.
// No dependencies.
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    localparam int RAW_NUM_W = 33;
    localparam int RAW_DEN_W = 32;
    localparam int FORM_W    = 3;
    localparam int WHOLE_W   = 33;
    localparam int FRAC_W    = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_opcode;

    typedef enum logic [FORM_W-1:0] {
        FORM_INT    = 3'd0,
        FORM_ZERO   = 3'd1,
        FORM_ONE    = 3'd2,
        FORM_PROPER = 3'd3,
        FORM_WHOLE  = 3'd4,
        FORM_MIXED  = 3'd5
    } t_form;

    typedef enum logic [1:0] {
        MS_P0,
        MS_P1,
        MS_RD
    } t_mul_sel;

    typedef enum logic [1:0] {
        DOP_GCD,
        DOP_TA,
        DOP_TB,
        DOP_WH
    } t_div_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_CLASS,
        S_GCD_TEST,
        S_GCD_WAIT,
        S_TA,
        S_TA_WAIT,
        S_TB,
        S_TB_WAIT,
        S_WH,
        S_WH_WAIT,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_ALIGN,
        DV_SUB
    } t_dv_state;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum_en;
        logic     gcd_init;
        logic     div_start;
        t_div_op  div_op;
        logic     out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic special;
        logic b_zero;
        logic div_done;
    } t_dp_status;

endpackage

### sv/rar_in_if.sv
// Input channel of the rational arithmetic unit: valid, ready and the operand payload.
// Depends on rar_pkg.
interface rar_in_if import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      command;
    logic signed [OPERAND_WIDTH-1:0] first_num;
    logic signed [OPERAND_WIDTH-1:0] first_den;
    logic signed [OPERAND_WIDTH-1:0] second_num;
    logic signed [OPERAND_WIDTH-1:0] second_den;

    modport source (
        output valid, command, first_num, first_den, second_num, second_den,
        input  ready
    );
    modport sink (
        input  valid, command, first_num, first_den, second_num, second_den,
        output ready
    );
endinterface

### sv/rar_out_if.sv
// Result channel of the rational arithmetic unit: valid, ready and the result payload.
// Depends on rar_pkg.
interface rar_out_if import rar_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [RAW_NUM_W-1:0] raw_num;
    logic signed [RAW_DEN_W-1:0] raw_den;
    logic [FORM_W-1:0]           form;
    logic signed [WHOLE_W-1:0]   whole_part;
    logic signed [FRAC_W-1:0]    frac_num;
    logic signed [FRAC_W-1:0]    frac_den;

    modport source (
        output valid, raw_num, raw_den, form, whole_part, frac_num, frac_den,
        input  ready
    );
    modport sink (
        input  valid, raw_num, raw_den, form, whole_part, frac_num, frac_den,
        output ready
    );
endinterface

### sv/rar_div.sv
// Iterative unsigned divider: aligns the divisor up, then shifts and subtracts
// one quotient bit a cycle. Depends on rar_pkg.
module rar_div import rar_pkg::*; #(
    parameter int MAG_WIDTH = 2 * OPERAND_WIDTH_DEF + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MAG_WIDTH-1:0] i_dividend,
    input  logic [MAG_WIDTH-1:0] i_divisor,
    output logic                 o_done,
    output logic [MAG_WIDTH-1:0] o_quo,
    output logic [MAG_WIDTH-1:0] o_rem
);
    localparam int CW = $clog2(MAG_WIDTH);

    t_dv_state            r_state, n_state;
    logic [MAG_WIDTH-1:0] r_rem, r_dvs, r_quo;
    logic [CW-1:0]        r_cnt;
    logic                 r_done;
    logic                 w_align_ok;
    logic                 w_ge;

    assign w_align_ok = ({r_dvs, 1'b0} <= {1'b0, r_rem}) && (r_cnt != CW'(MAG_WIDTH - 1));
    assign w_ge       = r_rem >= r_dvs;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE:  if (i_start) n_state = DV_ALIGN;
            DV_ALIGN: if (!w_align_ok) n_state = DV_SUB;
            DV_SUB:   if (r_cnt == '0) n_state = DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == DV_SUB) && (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    r_rem <= i_dividend;
                    r_dvs <= i_divisor;
                    r_quo <= '0;
                    r_cnt <= '0;
                end
            end
            DV_ALIGN: begin
                if (w_align_ok) begin
                    r_dvs <= {r_dvs[MAG_WIDTH-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            DV_SUB: begin
                r_rem <= w_ge ? (r_rem - r_dvs) : r_rem;
                r_quo <= {r_quo[MAG_WIDTH-2:0], w_ge};
                if (r_cnt != '0) begin
                    r_dvs <= {1'b0, r_dvs[MAG_WIDTH-1:1]};
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == DV_IDLE)
        else $error("divider started while busy");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < r_dvs)
        else $error("remainder not below divisor at completion");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");
`endif
endmodule

### sv/rar_dp.sv
// Datapath: operand registers, shared multiplier, raw result, Euclid registers with the
// shared divider, and the result register. Depends on rar_pkg and rar_div.
module rar_dp import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_ctrl_cmd                       i_cmd,
    output t_dp_status                      o_status,
    input  logic [1:0]                      i_command,
    input  logic signed [OPERAND_WIDTH-1:0] i_first_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_first_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_second_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_second_den,
    output logic signed [RAW_NUM_W-1:0]     o_raw_num,
    output logic signed [RAW_DEN_W-1:0]     o_raw_den,
    output logic [FORM_W-1:0]               o_form,
    output logic signed [WHOLE_W-1:0]       o_whole_part,
    output logic signed [FRAC_W-1:0]        o_frac_num,
    output logic signed [FRAC_W-1:0]        o_frac_den
);
    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * OPERAND_WIDTH + 1;

    t_opcode               r_op;
    logic signed [W-1:0]   r_n1, r_d1, r_n2, r_d2;
    logic signed [2*W-1:0] r_p0, r_p1;
    logic signed [MW-1:0]  r_rn, r_rd, r_a, r_b, r_ta, r_tb, r_whole, r_fnum;
    t_div_op               r_dop;
    logic                  r_qneg, r_rneg;

    logic signed [W-1:0]   w_mx, w_my;
    logic signed [2*W-1:0] w_prod;
    logic signed [MW-1:0]  w_s0, w_s1, w_rn;
    logic signed [MW-1:0]  w_sel_n, w_sel_d;
    logic [MW-1:0]         w_mag_n, w_mag_d;
    logic                  w_done;
    logic [MW-1:0]         w_quo, w_rem;
    logic signed [MW-1:0]  w_qs, w_rs;
    logic                  w_rd_one, w_rn_zero, w_rn_eq;

    logic signed [RAW_NUM_W-1:0] r_o_raw_num;
    logic signed [RAW_DEN_W-1:0] r_o_raw_den;
    t_form                       r_o_form;
    logic signed [WHOLE_W-1:0]   r_o_whole;
    logic signed [FRAC_W-1:0]    r_o_fnum, r_o_fden;

    // One multiplier serves all three products.
    always_comb begin
        w_mx = r_n1;
        w_my = r_d2;
        unique case (i_cmd.mul_sel)
            MS_P0: begin
                w_mx = r_n1;
                w_my = (r_op == OP_MUL) ? r_n2 : r_d2;
            end
            MS_P1: begin
                w_mx = r_d1;
                w_my = r_n2;
            end
            MS_RD: begin
                w_mx = r_d1;
                w_my = (r_op == OP_DIV) ? r_n2 : r_d2;
            end
            default: ;
        endcase
    end

    assign w_prod = w_mx * w_my;

    assign w_s0 = MW'(r_p0);
    assign w_s1 = MW'(r_p1);

    always_comb begin
        unique case (r_op)
            OP_ADD:  w_rn = w_s0 + w_s1;
            OP_SUB:  w_rn = w_s0 - w_s1;
            default: w_rn = w_s0;
        endcase
        if (r_rd == '0) w_rn = '0;
    end

    assign w_rd_one  = r_rd == MW'(1);
    assign w_rn_zero = r_rn == '0;
    assign w_rn_eq   = r_rn == r_rd;

    always_comb begin
        unique case (i_cmd.div_op)
            DOP_GCD: begin w_sel_n = r_a;  w_sel_d = r_b;  end
            DOP_TA:  begin w_sel_n = r_rn; w_sel_d = r_a;  end
            DOP_TB:  begin w_sel_n = r_rd; w_sel_d = r_a;  end
            DOP_WH:  begin w_sel_n = r_ta; w_sel_d = r_tb; end
            default: begin w_sel_n = r_a;  w_sel_d = r_b;  end
        endcase
    end

    assign w_mag_n = w_sel_n[MW-1] ? (~w_sel_n + 1'b1) : w_sel_n;
    assign w_mag_d = w_sel_d[MW-1] ? (~w_sel_d + 1'b1) : w_sel_d;

    rar_div #(.MAG_WIDTH(MW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag_n),
        .i_divisor  (w_mag_d),
        .o_done     (w_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // Truncating division: the quotient is negative when the signs differ, and the
    // remainder takes the sign of the dividend.
    assign w_qs = r_qneg ? -$signed(w_quo) : $signed(w_quo);
    assign w_rs = r_rneg ? -$signed(w_rem) : $signed(w_rem);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_opcode'(i_command);
            r_n1 <= i_first_num;
            r_d1 <= i_first_den;
            r_n2 <= i_second_num;
            r_d2 <= i_second_den;
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                MS_P0:   r_p0 <= w_prod;
                MS_P1:   r_p1 <= w_prod;
                MS_RD:   r_rd <= MW'(w_prod);
                default: ;
            endcase
        end
        if (i_cmd.sum_en) r_rn <= w_rn;
        if (i_cmd.gcd_init) begin
            r_a <= r_rn;
            r_b <= r_rd;
        end
        if (i_cmd.div_start) begin
            r_dop  <= i_cmd.div_op;
            r_qneg <= w_sel_n[MW-1] ^ w_sel_d[MW-1];
            r_rneg <= w_sel_n[MW-1];
        end
        if (w_done) begin
            unique case (r_dop)
                DOP_GCD: begin
                    r_a <= r_b;
                    r_b <= w_rs;
                end
                DOP_TA: r_ta <= w_qs;
                DOP_TB: r_tb <= w_qs;
                DOP_WH: begin
                    r_whole <= w_qs;
                    r_fnum  <= w_rs;
                end
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_raw_num <= RAW_NUM_W'(r_rn);
            r_o_raw_den <= RAW_DEN_W'(r_rd);
            priority if (w_rd_one) begin
                r_o_form  <= FORM_INT;
                r_o_whole <= WHOLE_W'(r_rn);
                r_o_fnum  <= '0;
                r_o_fden  <= FRAC_W'(1);
            end else if (w_rn_zero) begin
                r_o_form  <= FORM_ZERO;
                r_o_whole <= '0;
                r_o_fnum  <= '0;
                r_o_fden  <= FRAC_W'(1);
            end else if (w_rn_eq) begin
                r_o_form  <= FORM_ONE;
                r_o_whole <= WHOLE_W'(1);
                r_o_fnum  <= '0;
                r_o_fden  <= FRAC_W'(1);
            end else begin
                r_o_whole <= WHOLE_W'(r_whole);
                r_o_fnum  <= FRAC_W'(r_fnum);
                r_o_fden  <= FRAC_W'(r_tb);
                priority if (r_whole == '0) r_o_form <= FORM_PROPER;
                else if (r_fnum == '0)      r_o_form <= FORM_WHOLE;
                else                        r_o_form <= FORM_MIXED;
            end
        end
    end

    assign o_status.special  = w_rd_one || w_rn_zero || w_rn_eq;
    assign o_status.b_zero   = r_b == '0;
    assign o_status.div_done = w_done;

    assign o_raw_num    = r_o_raw_num;
    assign o_raw_den    = r_o_raw_den;
    assign o_form       = r_o_form;
    assign o_whole_part = r_o_whole;
    assign o_frac_num   = r_o_fnum;
    assign o_frac_den   = r_o_fden;
endmodule

### sv/rar_ctrl.sv
// Controller: sequences the products, classification, Euclid loop and final divisions,
// and owns both handshakes. Depends on rar_pkg.
module rar_ctrl import rar_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_ctrl_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_MUL0;
            S_MUL0:     n_state = S_MUL1;
            S_MUL1:     n_state = S_MUL2;
            S_MUL2:     n_state = S_SUM;
            S_SUM:      n_state = S_CLASS;
            S_CLASS:    n_state = i_status.special ? S_FIN : S_GCD_TEST;
            S_GCD_TEST: n_state = i_status.b_zero ? S_TA : S_GCD_WAIT;
            S_GCD_WAIT: if (i_status.div_done) n_state = S_GCD_TEST;
            S_TA:       n_state = S_TA_WAIT;
            S_TA_WAIT:  if (i_status.div_done) n_state = S_TB;
            S_TB:       n_state = S_TB_WAIT;
            S_TB_WAIT:  if (i_status.div_done) n_state = S_WH;
            S_WH:       n_state = S_WH_WAIT;
            S_WH_WAIT:  if (i_status.div_done) n_state = S_FIN;
            S_FIN:      n_state = S_OUT;
            S_OUT:      if (i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.mul_sel = MS_P0;
        o_cmd.div_op  = DOP_GCD;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL0: begin o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MS_P0; end
            S_MUL1: begin o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MS_P1; end
            S_MUL2: begin o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MS_RD; end
            S_SUM:      o_cmd.sum_en = 1'b1;
            S_CLASS:    o_cmd.gcd_init = 1'b1;
            S_GCD_TEST: o_cmd.div_start = !i_status.b_zero;
            S_TA:  begin o_cmd.div_start = 1'b1; o_cmd.div_op = DOP_TA; end
            S_TB:  begin o_cmd.div_start = 1'b1; o_cmd.div_op = DOP_TB; end
            S_WH:  begin o_cmd.div_start = 1'b1; o_cmd.div_op = DOP_WH; end
            S_FIN:      o_cmd.out_load = 1'b1;
            S_OUT:      o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

### sv/rational_alu_reduce.sv
// Rational arithmetic unit with GCD reduction. One item is in work at a time: after a
// transfer on the input channel the block forms the three products on one shared
// multiplier, then the raw sum and the classification, then runs Euclid and three
// final divisions on one shared shift-and-subtract divider. Integer, zero and unity
// results skip the divider. The result is held until its transfer, and the next item
// is taken in the cycle after that.
// Depends on rar_pkg, rar_in_if, rar_out_if, rar_ctrl and rar_dp.
module rational_alu_reduce import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    rar_in_if.sink     i_in,
    rar_out_if.source  o_out
);
    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;

    rar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    rar_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_command    (i_in.command),
        .i_first_num  (i_in.first_num),
        .i_first_den  (i_in.first_den),
        .i_second_num (i_in.second_num),
        .i_second_den (i_in.second_den),
        .o_raw_num    (o_out.raw_num),
        .o_raw_den    (o_out.raw_den),
        .o_form       (o_out.form),
        .o_whole_part (o_out.whole_part),
        .o_frac_num   (o_out.frac_num),
        .o_frac_den   (o_out.frac_den)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
endmodule

### sim/tb_rational_alu_reduce.sv
// Self-checking testbench for rational_alu_reduce: a directed table, then random fractions.
// Depends on rar_pkg, rar_in_if, rar_out_if and the block itself.
`timescale 1ns / 1ps

module tb_rational_alu_reduce;
    import rar_pkg::*;

    localparam int OW         = OPERAND_WIDTH_DEF;
    localparam int N_RANDOM   = 1950;
    localparam int CYCLE_CAP  = 10000000;
    localparam int DRAIN_WAIT = 400;

    typedef struct {
        logic signed [RAW_NUM_W-1:0] raw_num;
        logic signed [RAW_DEN_W-1:0] raw_den;
        t_form                       form;
        logic signed [WHOLE_W-1:0]   whole_part;
        logic signed [FRAC_W-1:0]    frac_num;
        logic signed [FRAC_W-1:0]    frac_den;
    } t_quotient;

    typedef struct {
        t_opcode             op;
        logic signed [15:0]  n1, d1, n2, d2;
        logic                known;
        t_quotient           res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   fail_count;

    rar_in_if  #(.OPERAND_WIDTH(OW)) in_ch ();
    rar_out_if                       out_ch ();

    rational_alu_reduce #(.OPERAND_WIDTH(OW)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_quotient pending_q[$];
    t_row      table_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_quotient reduce_fraction(t_opcode op, logic signed [15:0] a,
                                                  logic signed [15:0] b,
                                                  logic signed [15:0] c,
                                                  logic signed [15:0] d);
        t_quotient q;
        longint n1, d1, n2, d2, rn, rd, g, x, y, t, ta, tb, wh, fn, fd;
        n1 = a; d1 = b; n2 = c; d2 = d;
        wh = 0; fn = 0; fd = 1;
        case (op)
            OP_ADD: begin rn = n1 * d2 + d1 * n2; rd = d1 * d2; end
            OP_SUB: begin rn = n1 * d2 - d1 * n2; rd = d1 * d2; end
            OP_MUL: begin rn = n1 * n2;           rd = d1 * d2; end
            default: begin rn = n1 * d2;          rd = d1 * n2; end
        endcase
        if (rd == 0) rn = 0;
        if (rd == 1) begin
            q.form = FORM_INT;
            wh = rn;
        end else if (rn == 0) begin
            q.form = FORM_ZERO;
        end else if (rn == rd) begin
            q.form = FORM_ONE;
            wh = 1;
        end else begin
            x = rn; y = rd;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            g = x;
            ta = rn / g;
            tb = rd / g;
            wh = ta / tb;
            fn = ta % tb;
            fd = tb;
            if (wh == 0)       q.form = FORM_PROPER;
            else if (fn == 0)  q.form = FORM_WHOLE;
            else               q.form = FORM_MIXED;
        end
        q.raw_num    = rn[RAW_NUM_W-1:0];
        q.raw_den    = rd[RAW_DEN_W-1:0];
        q.whole_part = wh[WHOLE_W-1:0];
        q.frac_num   = fn[FRAC_W-1:0];
        q.frac_den   = fd[FRAC_W-1:0];
        return q;
    endfunction

    function automatic t_quotient simple_result(longint rn, longint rd, t_form f,
                                                longint wh);
        t_quotient q;
        q.raw_num = rn[RAW_NUM_W-1:0];
        q.raw_den = rd[RAW_DEN_W-1:0];
        q.form = f;
        q.whole_part = wh[WHOLE_W-1:0];
        q.frac_num = '0;
        q.frac_den = FRAC_W'(1);
        return q;
    endfunction

    task automatic add_row(t_opcode op, int a, int b, int c, int d, logic known,
                           t_quotient q);
        t_row r;
        r.op = op; r.n1 = 16'(a); r.d1 = 16'(b); r.n2 = 16'(c); r.d2 = 16'(d);
        r.known = known; r.res = q;
        table_rows.push_back(r);
    endtask

    // Operand values lean on small magnitudes and the edges, so that reduction does work.
    function automatic logic signed [15:0] pick_operand();
        int s;
        s = $urandom_range(0, 9);
        if (s < 4) return 16'($signed($urandom_range(0, 40)) - 20);
        if (s == 4) return 16'($urandom_range(0, 3) == 0 ? 16'h8000 :
                              ($urandom_range(0, 1) ? 16'h7fff : 16'hffff));
        if (s < 7) return 16'($signed($urandom_range(0, 2000)) - 1000);
        return 16'($urandom());
    endfunction

    task automatic send_item(t_opcode op, logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c, logic signed [15:0] d);
        in_ch.valid      <= 1'b1;
        in_ch.command    <= op;
        in_ch.first_num  <= a;
        in_ch.first_den  <= b;
        in_ch.second_num <= c;
        in_ch.second_den <= d;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic maybe_gap(ref int burst_left);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: stalls in runs, with occasional long clean stretches.
    initial begin
        int run;
        logic stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            run = $urandom_range(1, 20);
            stall = $urandom_range(0, 2) == 0;
            repeat (run) begin
                out_ch.ready <= ~stall;
                @(posedge i_clk);
            end
        end
    end

    // Checking at each result transfer.
    always @(posedge i_clk) begin
        t_quotient e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: result with nothing pending, raw %0d/%0d", $time,
                         out_ch.raw_num, out_ch.raw_den);
                fail_count++;
            end else begin
                e = pending_q.pop_front();
                if (out_ch.raw_num !== e.raw_num || out_ch.raw_den !== e.raw_den ||
                    out_ch.form !== e.form || out_ch.whole_part !== e.whole_part ||
                    out_ch.frac_num !== e.frac_num || out_ch.frac_den !== e.frac_den) begin
                    $display("%0t: expected %0d/%0d form %0d whole %0d frac %0d/%0d", $time,
                             e.raw_num, e.raw_den, e.form, e.whole_part, e.frac_num,
                             e.frac_den);
                    $display("%0t: actual   %0d/%0d form %0d whole %0d frac %0d/%0d", $time,
                             out_ch.raw_num, out_ch.raw_den, out_ch.form, out_ch.whole_part,
                             out_ch.frac_num, out_ch.frac_den);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP) begin
                $display("tb_rational_alu_reduce: errors");
                $finish;
            end
        end
    end

    initial begin
        t_quotient q;
        t_opcode   op;
        int        burst;
        fail_count = 0;
        burst = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = '0;
        in_ch.first_num = '0;
        in_ch.first_den = '0;
        in_ch.second_num = '0;
        in_ch.second_den = '0;

        // Rows with plain answers: integer, zero denominator, zero, unity.
        add_row(OP_ADD, 1, 1, 2, 1, 1'b1, simple_result(3, 1, FORM_INT, 3));
        add_row(OP_SUB, 5, 0, 3, 7, 1'b1, simple_result(0, 0, FORM_ZERO, 0));
        add_row(OP_MUL, 0, 3, 9, 4, 1'b1, simple_result(0, 12, FORM_ZERO, 0));
        add_row(OP_DIV, 3, 4, 3, 4, 1'b1, simple_result(12, 12, FORM_ONE, 1));
        add_row(OP_DIV, 7, 2, 0, 5, 1'b1, simple_result(0, 0, FORM_ZERO, 0));
        add_row(OP_MUL, -32768, 1, -32768, 1, 1'b1,
                simple_result(64'sd1073741824, 1, FORM_INT, 64'sd1073741824));
        add_row(OP_SUB, -32768, -32768, -32768, -32768, 1'b1,
                simple_result(0, 64'sd1073741824, FORM_ZERO, 0));
        add_row(OP_ADD, 32767, -1, 32767, -1, 1'b1,
                simple_result(-65534, 1, FORM_INT, -65534));
        // Rows left to the predictor: proper, whole, mixed, negatives, extremes.
        add_row(OP_ADD, 1, 2, 1, 3, 1'b0, q);
        add_row(OP_MUL, 6, 4, 2, 3, 1'b0, q);
        add_row(OP_SUB, 7, 3, -5, 6, 1'b0, q);
        add_row(OP_DIV, -9, 4, 3, -8, 1'b0, q);
        add_row(OP_ADD, 32767, 32767, -32768, 32767, 1'b0, q);
        add_row(OP_ADD, -32768, 32767, -32768, 32767, 1'b0, q);
        add_row(OP_SUB, 32767, -32768, -32768, 32767, 1'b0, q);
        add_row(OP_MUL, 32767, -32768, 32767, -32768, 1'b0, q);
        add_row(OP_DIV, -32768, 3, 32767, -7, 1'b0, q);
        add_row(OP_DIV, 21845, -1, 1, -21846, 1'b0, q);
        add_row(OP_MUL, -1, -1, -1, -1, 1'b0, q);
        add_row(OP_ADD, -1, 2, -1, 2, 1'b0, q);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) begin
            pending_q.push_back(table_rows[k].known ? table_rows[k].res :
                reduce_fraction(table_rows[k].op, table_rows[k].n1, table_rows[k].d1,
                                table_rows[k].n2, table_rows[k].d2));
            send_item(table_rows[k].op, table_rows[k].n1, table_rows[k].d1,
                      table_rows[k].n2, table_rows[k].d2);
            maybe_gap(burst);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            logic signed [15:0] a, b, c, d;
            op = t_opcode'($urandom_range(0, 3));
            a = pick_operand(); b = pick_operand();
            c = pick_operand(); d = pick_operand();
            pending_q.push_back(reduce_fraction(op, a, b, c, d));
            send_item(op, a, b, c, d);
            if (k == N_RANDOM / 2) begin
                // Let the pipeline empty once before carrying on.
                in_ch.valid <= 1'b0;
                while (pending_q.size() != 0) @(posedge i_clk);
            end else begin
                maybe_gap(burst);
            end
        end
        in_ch.valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_rational_alu_reduce: clean");
        end else begin
            $display("tb_rational_alu_reduce: errors");
        end
        $finish;
    end
endmodule
